// ===== rtl/rrq_pkg.sv =====
// Shared types and constants for the retransmission queue.
// Holds the command and result transaction structs, command and status codes,
// register indexes and the result struct of the shared compare unit.
package rrq_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RESEND_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIFESPAN  = 2'd1;

  localparam logic [15:0] RESEND_INTERVAL_RST = 16'd250;
  localparam logic [31:0] ENTRY_LIFESPAN_RST  = 32'd10000;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] msg_id;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        resend_valid;
    logic        expired_valid;
    logic [31:0] front_id;
    logic [4:0]  entries;
  } out_t;

  typedef struct packed {
    logic eq;
    logic ge;
  } cmp_res_t;

endpackage

// ===== rtl/rrq_cmp.sv =====
// Shared compare unit of the retransmission queue.
// Gives equality of two words and whether their wrapping difference reaches
// a limit. Depends on rrq_pkg.
module rrq_cmp (
  input  logic [31:0]       op_a,
  input  logic [31:0]       op_b,
  input  logic [31:0]       op_lim,
  output rrq_pkg::cmp_res_t res
);

  logic [31:0] diff;

  assign diff   = op_a - op_b;
  assign res.eq = (op_a == op_b);
  assign res.ge = (diff >= op_lim);

endmodule

// ===== rtl/rrq_store.sv =====
// Entry memories of the retransmission queue: message IDs and add times.
// One write port and one registered read port, shared by both arrays.
// No package dependency.
module rrq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_id,
  output logic [31:0]   rd_time,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_id,
  input  logic [31:0]   wr_time
);

  logic [31:0] id_mem   [DEPTH];
  logic [31:0] time_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]   <= wr_id;
      time_mem[wr_addr] <= wr_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id   <= id_mem[rd_addr];
      rd_time <= time_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/reliable_retransmit_queue_top.sv =====
// Top level of the retransmission queue: sequencer, counters, config registers.
// Instantiates rrq_store and rrq_cmp; uses rrq_pkg.
//
// Usage:
//   A command transaction is taken when start is high and busy is low. Add
//   appends msg_id with its time unless it is queued already or the queue is
//   full; acknowledge removes every entry with msg_id; tick checks the oldest
//   entry once resend_interval ms have passed since the last check, and then
//   reports it for resending or drops it as expired.
//   Exactly one result per command appears on out_data for one cycle, marked
//   by out_valid. The receiver cannot stall, so the result must be captured.
//   Busy drops in the cycle the result is shown, so a new command can follow.
//   Add and acknowledge read the queue one entry a cycle. A tick first checks
//   whether it is due; if so and the queue holds entries, it reads the oldest
//   entry and either reports it for resending or, if it has expired, adds an
//   acknowledge-style walk. Unknown commands answer in the next cycle.
//   Register writes on the cfg channel are always ready and must only be made
//   while the block is idle.
//   Reset empties the queue, clears the last check time and loads the default
//   interval (250 ms) and lifespan (10000 ms).
module reliable_retransmit_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rrq_pkg::in_t                  in_data,
  output logic                          out_valid,
  output rrq_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TCHK  = 2'd1;
  localparam logic [1:0] S_FRONT = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic             hit_r, hit_nxt;
  logic             pend_r, pend_nxt;
  rrq_pkg::out_t    out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      interval_r;
  logic [31:0]      lifespan_r;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [31:0]      rd_id;
  logic [31:0]      rd_time;
  logic             we;
  logic [AW-1:0]    wr_addr;
  logic [31:0]      wr_id;
  logic [31:0]      wr_time;

  logic [31:0]       cmp_a;
  logic [31:0]       cmp_b;
  logic [31:0]       cmp_lim;
  rrq_pkg::cmp_res_t cmp;

  rrq_store #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_id  (rd_id),
    .rd_time(rd_time),
    .wr_en  (we),
    .wr_addr(wr_addr),
    .wr_id  (wr_id),
    .wr_time(wr_time)
  );

  rrq_cmp u_cmp (
    .op_a  (cmp_a),
    .op_b  (cmp_b),
    .op_lim(cmp_lim),
    .res   (cmp)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    rrq_pkg::out_t res;
    res           = '0;
    res.entries   = 5'(count_r);
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    hit_nxt       = hit_r;
    pend_nxt      = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    we            = 1'b0;
    wr_addr       = '0;
    wr_id         = rd_id;
    wr_time       = rd_time;
    cmp_a         = key_r;
    cmp_b         = rd_id;
    cmp_lim       = lifespan_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_data.command;
          key_nxt = in_data.msg_id;
          now_nxt = in_data.now_ms;
          rd_nxt  = '0;
          wr_nxt  = '0;
          hit_nxt = 1'b0;
          unique case (in_data.command) inside
            rrq_pkg::CMD_ADD, rrq_pkg::CMD_ACK: state_nxt = S_SCAN;
            rrq_pkg::CMD_TICK:                  state_nxt = S_TCHK;
            default: begin
              out_nxt       = res;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_TCHK: begin
        cmp_a   = now_r;
        cmp_b   = last_r;
        cmp_lim = 32'(interval_r);
        if (cmp.ge) begin
          last_nxt = now_r;
        end
        if (cmp.ge && (count_r != '0)) begin
          rd_en     = 1'b1;
          state_nxt = S_FRONT;
        end else begin
          out_nxt       = res;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FRONT: begin
        cmp_a   = now_r;
        cmp_b   = rd_time;
        cmp_lim = lifespan_r;
        if (cmp.ge) begin
          // Expired: drop every entry carrying the oldest ID by a removal walk.
          key_nxt   = rd_id;
          state_nxt = S_SCAN;
        end else begin
          res.resend_valid = 1'b1;
          res.front_id     = rd_id;
          out_nxt          = res;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_r < count_r) begin
          rd_en    = 1'b1;
          rd_addr  = rd_r[AW-1:0];
          rd_nxt   = rd_r + 1'b1;
          pend_nxt = 1'b1;
        end
        // The entry read last cycle is compared now; survivors of a removal
        // are copied down to the write pointer, which never passes the reads.
        if (pend_r) begin
          if (cmp.eq) begin
            hit_nxt = 1'b1;
          end else if (cmd_r != rrq_pkg::CMD_ADD) begin
            we      = 1'b1;
            wr_addr = wr_r[AW-1:0];
            wr_nxt  = wr_r + 1'b1;
          end
        end
        if ((rd_r >= count_r) && !pend_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          case (cmd_r)
            rrq_pkg::CMD_ADD: begin
              if (hit_r) begin
                res.status = rrq_pkg::STAT_MISS;
              end else if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
                res.status = rrq_pkg::STAT_FULL;
              end else begin
                we        = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_id     = key_r;
                wr_time   = now_r;
                count_nxt = count_r + 1'b1;
              end
            end
            rrq_pkg::CMD_ACK: begin
              count_nxt  = wr_r;
              res.status = hit_r ? rrq_pkg::STAT_DONE : rrq_pkg::STAT_MISS;
            end
            default: begin
              count_nxt         = wr_r;
              res.expired_valid = 1'b1;
              res.front_id      = key_r;
            end
          endcase
          res.entries = 5'(count_nxt);
          out_nxt     = res;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      last_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    now_r <= now_nxt;
    rd_r  <= rd_nxt;
    wr_r  <= wr_nxt;
    hit_r <= hit_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= rrq_pkg::RESEND_INTERVAL_RST;
      lifespan_r <= rrq_pkg::ENTRY_LIFESPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rrq_pkg::REG_RESEND_INTERVAL: interval_r <= cfg_data[15:0];
        rrq_pkg::REG_ENTRY_LIFESPAN:  lifespan_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rrq_checker.sv =====
// Port-level checks for the retransmission queue, bound to the top level.
// Depends on rrq_pkg and reliable_retransmit_queue_top.
module rrq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input rrq_pkg::in_t  in_data,
  input logic          out_valid,
  input rrq_pkg::out_t out_data
);

  // A result always ends the transaction, so the block is free while it shows.
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.entries) <= QUEUE_DEPTH) || (QUEUE_DEPTH > 31))
    else $error("entry count beyond queue depth");

  a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.resend_valid && out_data.expired_valid))
    else $error("resend and expiry reported together");

  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != rrq_pkg::STAT_DONE)) |->
      (!out_data.resend_valid && !out_data.expired_valid && (out_data.front_id == '0)))
    else $error("failed command reported a front entry");

  a_unknown_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.command != rrq_pkg::CMD_ADD) &&
     (in_data.command != rrq_pkg::CMD_ACK) && (in_data.command != rrq_pkg::CMD_TICK))
      |=> (out_valid && !busy))
    else $error("unknown command not answered at once");

endmodule

bind reliable_retransmit_queue_top rrq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rrq_checker (.*);
